/* hw/rtl/fspa_pkg.sv */
package fspa_pkg;

  localparam int unsigned Capacity   = 1024;
  localparam int unsigned HandleW    = 10;
  localparam int unsigned AddrW      = $clog2(Capacity);
  localparam int unsigned CntW       = $clog2(Capacity + 1);
  localparam int unsigned LinkW      = HandleW + 1;
  localparam int unsigned CmdW       = 2;
  localparam int unsigned ElemSizeW  = 13;
  localparam int unsigned BlockSizeW = 11;
  localparam int unsigned OffsetW    = 22;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 13;
  localparam int unsigned DivCntW    = $clog2(HandleW + 1);

  localparam logic [CfgIdxW-1:0] CfgElementSize = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBlockSize   = 1'b1;

  localparam logic [ElemSizeW-1:0]  ElemSizeRst  = 13'd8;
  localparam logic [ElemSizeW-1:0]  ElemSizeMin  = 13'd8;
  localparam logic [ElemSizeW-1:0]  ElemSizeMax  = 13'd4096;
  localparam logic [BlockSizeW-1:0] BlockSizeRst = 11'd64;
  localparam logic [BlockSizeW-1:0] BlockSizeMin = 11'd1;
  localparam logic [BlockSizeW-1:0] BlockSizeMax = 11'd1024;

  typedef enum logic [CmdW-1:0] {
    CmdAlloc   = 2'd0,
    CmdFree    = 2'd1,
    CmdFreeAll = 2'd2,
    CmdNop     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StPop,
    StDiv,
    StMul,
    StDone
  } state_e;

endpackage

/* hw/rtl/fspa_if.sv */
interface fspa_req_if;
  logic                         valid;
  logic                         ready;
  logic [fspa_pkg::CmdW-1:0]    command;
  logic [fspa_pkg::HandleW-1:0] handle_in;

  modport source (output valid, output command, output handle_in, input ready);
  modport sink (input valid, input command, input handle_in, output ready);
endinterface

interface fspa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [fspa_pkg::HandleW-1:0] handle;
  logic [fspa_pkg::HandleW-1:0] block_number;
  logic [fspa_pkg::HandleW-1:0] slot;
  logic [fspa_pkg::OffsetW-1:0] byte_offset;
  logic                         from_free_list;
  logic                         status;

  modport source (
    output valid, output handle, output block_number, output slot,
    output byte_offset, output from_free_list, output status, input ready
  );
  modport sink (
    input valid, input handle, input block_number, input slot,
    input byte_offset, input from_free_list, input status, output ready
  );
endinterface

/* hw/rtl/fspa_ram.sv */
module fspa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/fixed_size_pool_allocator.sv */
// Fixed-size pool allocator: every request beat (allocate, free, free all) yields exactly one
// response beat. Allocate pops the LIFO free list, whose links live in a single-port memory of
// Capacity entries, and falls back to bump allocation when the list is empty; status flags an
// exhausted pool. Free and free all return an all-zero response with no divide or multiply, a bump
// allocation after a multiply for the byte offset, and a recycled handle after one link-memory
// read, then a bit-serial divider that takes one handle bit per cycle to split the handle into
// block and slot by block_size, then a multiply for the byte offset. A new request is taken
// while the previous response still waits in the output register. Write the configuration
// registers only while no request is in flight.
module fixed_size_pool_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fspa_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [fspa_pkg::CfgDataW-1:0]   cfg_wdata_i,
  fspa_req_if.sink                        req,
  fspa_rsp_if.source                      rsp
);

  fspa_pkg::state_e state_q, state_d;

  logic [fspa_pkg::ElemSizeW-1:0]  element_size_q;
  logic [fspa_pkg::BlockSizeW-1:0] block_size_q;
  logic [fspa_pkg::ElemSizeW-1:0]  es_eff;
  logic [fspa_pkg::BlockSizeW-1:0] bs_eff;

  logic [fspa_pkg::HandleW-1:0]    free_head_q, free_head_d;
  logic                            empty_q, empty_d;
  logic [fspa_pkg::HandleW-1:0]    bump_slot_q, bump_slot_d;
  logic [fspa_pkg::BlockSizeW-1:0] bump_block_q, bump_block_d;
  logic [fspa_pkg::CntW-1:0]       bump_count_q, bump_count_d;

  logic [fspa_pkg::HandleW-1:0]    h_q, h_d;
  logic [fspa_pkg::HandleW-1:0]    blk_q, blk_d;
  logic [fspa_pkg::HandleW-1:0]    slt_q, slt_d;
  logic                            rec_q, rec_d;
  logic                            stat_q, stat_d;
  logic [fspa_pkg::HandleW-1:0]    dvd_q, dvd_d;
  logic [fspa_pkg::HandleW-1:0]    rem_q, rem_d;
  logic [fspa_pkg::DivCntW-1:0]    div_cnt_q, div_cnt_d;
  logic [fspa_pkg::OffsetW-1:0]    prod_q, prod_d;

  logic                            out_valid_q, out_valid_d;
  logic [fspa_pkg::HandleW-1:0]    out_handle_q;
  logic [fspa_pkg::HandleW-1:0]    out_block_q;
  logic [fspa_pkg::HandleW-1:0]    out_slot_q;
  logic [fspa_pkg::OffsetW-1:0]    out_offset_q;
  logic                            out_rec_q;
  logic                            out_stat_q;
  logic                            out_load;

  logic                            req_accept;
  fspa_pkg::cmd_e                  cmd;
  logic                            handle_ok;
  logic                            exhausted;
  logic [fspa_pkg::BlockSizeW-1:0] slot_inc;
  logic                            slot_wrap;
  logic [fspa_pkg::BlockSizeW-1:0] bs_m1;
  logic [fspa_pkg::BlockSizeW-1:0] trial;
  logic [fspa_pkg::BlockSizeW-1:0] trial_diff;
  logic                            trial_ge;
  logic [fspa_pkg::HandleW+fspa_pkg::ElemSizeW-1:0] prod_full;

  logic                            ram_we;
  logic                            ram_re;
  logic [fspa_pkg::AddrW-1:0]      ram_addr;
  logic [fspa_pkg::LinkW-1:0]      ram_wdata;
  logic [fspa_pkg::LinkW-1:0]      ram_rdata;

  // effective register values
  always_comb begin
    if (element_size_q < fspa_pkg::ElemSizeMin) begin
      es_eff = fspa_pkg::ElemSizeMin;
    end else if (element_size_q > fspa_pkg::ElemSizeMax) begin
      es_eff = fspa_pkg::ElemSizeMax;
    end else begin
      es_eff = element_size_q;
    end
  end

  always_comb begin
    if (block_size_q < fspa_pkg::BlockSizeMin) begin
      bs_eff = fspa_pkg::BlockSizeMin;
    end else if (block_size_q > fspa_pkg::BlockSizeMax) begin
      bs_eff = fspa_pkg::BlockSizeMax;
    end else begin
      bs_eff = block_size_q;
    end
  end

  assign req.ready  = (state_q == fspa_pkg::StIdle);
  assign req_accept = req.valid & req.ready;
  assign cmd        = fspa_pkg::cmd_e'(req.command);
  assign handle_ok  = (fspa_pkg::CntW'(req.handle_in) < fspa_pkg::CntW'(fspa_pkg::Capacity));
  assign exhausted  = (bump_count_q >= fspa_pkg::CntW'(fspa_pkg::Capacity));

  assign slot_inc  = fspa_pkg::BlockSizeW'(bump_slot_q) + fspa_pkg::BlockSizeW'(1);
  assign slot_wrap = (slot_inc >= bs_eff);
  assign bs_m1     = bs_eff - fspa_pkg::BlockSizeW'(1);

  assign trial      = {rem_q, dvd_q[fspa_pkg::HandleW-1]};
  assign trial_ge   = (trial >= bs_eff);
  assign trial_diff = trial - bs_eff;

  assign prod_full = slt_q * es_eff;

  assign ram_we    = req_accept && (cmd == fspa_pkg::CmdFree) && handle_ok;
  assign ram_re    = req_accept && (cmd == fspa_pkg::CmdAlloc) && !empty_q;
  assign ram_addr  = ram_we ? req.handle_in : free_head_q;
  assign ram_wdata = empty_q ? {1'b1, fspa_pkg::HandleW'(0)} : {1'b0, free_head_q};

  fspa_ram #(
    .Width (fspa_pkg::LinkW),
    .Depth (fspa_pkg::Capacity)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign out_load = (state_q == fspa_pkg::StDone) && (!out_valid_q || rsp.ready);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fspa_pkg::StIdle: begin
        if (req_accept) begin
          if (cmd == fspa_pkg::CmdAlloc && !empty_q) begin
            state_d = fspa_pkg::StPop;
          end else if (cmd == fspa_pkg::CmdAlloc && !exhausted) begin
            state_d = fspa_pkg::StMul;
          end else begin
            state_d = fspa_pkg::StDone;
          end
        end
      end
      fspa_pkg::StPop: state_d = fspa_pkg::StDiv;
      fspa_pkg::StDiv: begin
        if (div_cnt_q == fspa_pkg::DivCntW'(fspa_pkg::HandleW - 1)) begin
          state_d = fspa_pkg::StMul;
        end
      end
      fspa_pkg::StMul: state_d = fspa_pkg::StDone;
      fspa_pkg::StDone: begin
        if (out_load) begin
          state_d = fspa_pkg::StIdle;
        end
      end
      default: state_d = fspa_pkg::StIdle;
    endcase
  end

  // datapath and pool state
  always_comb begin
    free_head_d  = free_head_q;
    empty_d      = empty_q;
    bump_slot_d  = bump_slot_q;
    bump_block_d = bump_block_q;
    bump_count_d = bump_count_q;
    h_d          = h_q;
    blk_d        = blk_q;
    slt_d        = slt_q;
    rec_d        = rec_q;
    stat_d       = stat_q;
    dvd_d        = dvd_q;
    rem_d        = rem_q;
    div_cnt_d    = div_cnt_q;
    prod_d       = prod_q;
    unique case (state_q)
      fspa_pkg::StIdle: begin
        if (req_accept) begin
          h_d       = '0;
          blk_d     = '0;
          slt_d     = '0;
          rec_d     = 1'b0;
          stat_d    = 1'b0;
          prod_d    = '0;
          dvd_d     = free_head_q;
          rem_d     = '0;
          div_cnt_d = '0;
          unique case (cmd)
            fspa_pkg::CmdAlloc: begin
              if (!empty_q) begin
                h_d   = free_head_q;
                rec_d = 1'b1;
              end else if (exhausted) begin
                stat_d = 1'b1;
              end else begin
                h_d          = bump_count_q[fspa_pkg::HandleW-1:0];
                bump_count_d = bump_count_q + fspa_pkg::CntW'(1);
                if (slot_wrap) begin
                  bump_slot_d  = '0;
                  bump_block_d = bump_block_q + fspa_pkg::BlockSizeW'(1);
                  slt_d        = '0;
                  blk_d        = bump_block_d[fspa_pkg::HandleW-1:0];
                end else begin
                  bump_slot_d = slot_inc[fspa_pkg::HandleW-1:0];
                  slt_d       = slot_inc[fspa_pkg::HandleW-1:0];
                  blk_d       = bump_block_q[fspa_pkg::HandleW-1:0];
                end
              end
            end
            fspa_pkg::CmdFree: begin
              if (handle_ok) begin
                free_head_d = req.handle_in;
                empty_d     = 1'b0;
              end
            end
            fspa_pkg::CmdFreeAll: begin
              bump_slot_d  = bs_m1[fspa_pkg::HandleW-1:0];
              bump_block_d = '1;
              bump_count_d = '0;
              free_head_d  = '0;
              empty_d      = 1'b1;
            end
            fspa_pkg::CmdNop: begin
            end
            default: begin
            end
          endcase
        end
      end
      fspa_pkg::StPop: begin
        if (ram_rdata[fspa_pkg::LinkW-1]) begin
          empty_d     = 1'b1;
          free_head_d = '0;
        end else begin
          free_head_d = ram_rdata[fspa_pkg::HandleW-1:0];
        end
      end
      fspa_pkg::StDiv: begin
        rem_d     = trial_ge ? trial_diff[fspa_pkg::HandleW-1:0]
                             : trial[fspa_pkg::HandleW-1:0];
        blk_d     = {blk_q[fspa_pkg::HandleW-2:0], trial_ge};
        dvd_d     = {dvd_q[fspa_pkg::HandleW-2:0], 1'b0};
        div_cnt_d = div_cnt_q + fspa_pkg::DivCntW'(1);
        slt_d     = rem_d;
      end
      fspa_pkg::StMul: begin
        prod_d = prod_full[fspa_pkg::OffsetW-1:0];
      end
      fspa_pkg::StDone: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= fspa_pkg::StIdle;
      element_size_q <= fspa_pkg::ElemSizeRst;
      block_size_q   <= fspa_pkg::BlockSizeRst;
      free_head_q    <= '0;
      empty_q        <= 1'b1;
      bump_slot_q    <= fspa_pkg::HandleW'(fspa_pkg::BlockSizeRst - fspa_pkg::BlockSizeW'(1));
      bump_block_q   <= '1;
      bump_count_q   <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_head_q  <= free_head_d;
      empty_q      <= empty_d;
      bump_slot_q  <= bump_slot_d;
      bump_block_q <= bump_block_d;
      bump_count_q <= bump_count_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == fspa_pkg::CfgElementSize) begin
          element_size_q <= cfg_wdata_i[fspa_pkg::ElemSizeW-1:0];
        end else if (cfg_idx_i == fspa_pkg::CfgBlockSize) begin
          block_size_q <= cfg_wdata_i[fspa_pkg::BlockSizeW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    h_q       <= h_d;
    blk_q     <= blk_d;
    slt_q     <= slt_d;
    rec_q     <= rec_d;
    stat_q    <= stat_d;
    dvd_q     <= dvd_d;
    rem_q     <= rem_d;
    div_cnt_q <= div_cnt_d;
    prod_q    <= prod_d;
    if (out_load) begin
      out_handle_q <= h_q;
      out_block_q  <= blk_q;
      out_slot_q   <= slt_q;
      out_offset_q <= prod_q;
      out_rec_q    <= rec_q;
      out_stat_q   <= stat_q;
    end
  end

  assign rsp.valid          = out_valid_q;
  assign rsp.handle         = out_handle_q;
  assign rsp.block_number   = out_block_q;
  assign rsp.slot           = out_slot_q;
  assign rsp.byte_offset    = out_offset_q;
  assign rsp.from_free_list = out_rec_q;
  assign rsp.status         = out_stat_q;

endmodule
